FILE: src/gfau_pkg.sv
// ----------------------------------------------------------------------------
// gfau_pkg
// Shared types and constants of the GF(256) arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gfau_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int ELEM_W      = 8;
	localparam int IDX_W       = 9;
	localparam int POLY_W      = 9;

	// field polynomial after reset (x^8 + x^4 + x^3 + x^2 + 1)
	localparam logic [POLY_W-1:0] POLY_RESET = 9'h11D;

	// last exponent of the build, it has no log entry
	localparam logic [ELEM_W-1:0] LAST_EXP = 8'hFF;
	// group order of the field
	localparam logic [IDX_W-1:0]  GROUP_ORDER = 9'd255;
	// build index once the tables are complete
	localparam logic [IDX_W-1:0]  BUILD_DONE = 9'd256;

	// operation codes
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_MUL   = 2'd1;
	localparam logic [1:0] CMD_INV   = 2'd2;
	localparam logic [1:0] CMD_ALPHA = 2'd3;

	// register index decoded from paddr
	localparam logic REG_FIELD_POLY = 1'b0;

	// request item
	typedef struct packed {
		logic [1:0]        command;
		logic [ELEM_W-1:0] operand_a;
		logic [ELEM_W-1:0] operand_b;
	} req_item_t;

	// response item
	typedef struct packed {
		logic [ELEM_W-1:0] field_result;
		logic              zero_inverse_error;
	} rsp_item_t;

	// table write bundle from the builder
	typedef struct packed {
		logic              pw_en;
		logic [ELEM_W-1:0] pw_addr;
		logic [ELEM_W-1:0] pw_data;
		logic              lw_en;
		logic [ELEM_W-1:0] lw_addr;
		logic [ELEM_W-1:0] lw_data;
	} bld_wr_t;

	// builder status
	typedef struct packed {
		logic             busy;
		logic [IDX_W-1:0] index;
	} bld_stat_t;

endpackage

`default_nettype wire

FILE: src/gfau_ram.sv
// ----------------------------------------------------------------------------
// gfau_ram
// Generic single-write, single-read RAM with registered read and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module gfau_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/gfau_builder.sv
// ----------------------------------------------------------------------------
// gfau_builder
// Table build sequencer: one power entry per step, one log entry per step
// but the last, and valid bits that make unreached log entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module gfau_builder import gfau_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   restart,
	input  wire logic [POLY_W-1:0]      poly,
	input  wire logic                   step,
	output bld_wr_t                     wr,
	output bld_stat_t                   stat,
	output logic      [TABLE_DEPTH-1:0] lval
);

	logic [IDX_W-1:0]       index_q;
	logic [ELEM_W-1:0]      elem_q;
	logic [TABLE_DEPTH-1:0] lval_q;
	logic                   busy;
	logic                   do_step;
	logic [ELEM_W-1:0]      idx;
	logic [ELEM_W-1:0]      elem_next;

	assign busy    = ~index_q[IDX_W-1];
	assign do_step = step & busy;
	assign idx     = index_q[ELEM_W-1:0];

	// alpha times the running element, reduced by the polynomial
	assign elem_next = {elem_q[ELEM_W-2:0], 1'b0} ^ (elem_q[ELEM_W-1] ? poly[ELEM_W-1:0] : '0);

	// table writes for this step
	always_comb begin
		wr.pw_en   = do_step;
		wr.pw_addr = idx;
		wr.pw_data = elem_q;
		wr.lw_en   = do_step & (idx != LAST_EXP);
		wr.lw_addr = elem_q;
		wr.lw_data = idx;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			elem_q  <= 8'd1;
			lval_q  <= '0;
		end else if (restart) begin
			index_q <= '0;
			elem_q  <= 8'd1;
			lval_q  <= '0;
		end else if (do_step) begin
			index_q <= index_q + 9'd1;
			elem_q  <= elem_next;
			if (idx != LAST_EXP) begin
				lval_q[elem_q] <= 1'b1;
			end
		end
	end

	assign stat.busy  = busy;
	assign stat.index = index_q;
	assign lval       = lval_q;

endmodule

`default_nettype wire

FILE: src/gfau_pipe.sv
// ----------------------------------------------------------------------------
// gfau_pipe
// Three-stage operation pipeline: log lookup, power lookup, result select.
// Items accepted during a table build are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module gfau_pipe import gfau_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	input  req_item_t                   req,
	output logic                        req_stall,
	output logic                        rsp_valid,
	output rsp_item_t                   rsp,
	input  wire logic                   rsp_stall,
	input  wire logic                   busy,
	input  wire logic [TABLE_DEPTH-1:0] lval,
	input  bld_wr_t                     wr
);

	logic v1_s1, v2_s2, v3_s3;
	logic en1, en2, en3;

	logic [1:0]        cmd_s1, cmd_s2;
	logic [ELEM_W-1:0] a_s1, b_s1, a_s2, b_s2;
	logic              va_s1, vb_s1;
	rsp_item_t         rsp_s3;

	logic [ELEM_W-1:0] log_a_raw, log_b_raw, pw_data;
	logic [ELEM_W-1:0] la, lb;
	logic [IDX_W-1:0]  lsum, lsum_red;
	logic [ELEM_W-1:0] pw_addr;
	rsp_item_t         res;

	// per-stage advance, a stage moves when empty or when the next one moves
	assign en3       = ~v3_s3 | ~rsp_stall;
	assign en2       = ~v2_s2 | en3;
	assign en1       = ~v1_s1 | en2;
	assign req_stall = ~en1;

	// log lookups for both operands
	gfau_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_log_a (
		.clk   (clk),
		.we    (wr.lw_en),
		.waddr (wr.lw_addr),
		.wdata (wr.lw_data),
		.re    (en1),
		.raddr (req.operand_a),
		.rdata (log_a_raw)
	);

	gfau_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_log_b (
		.clk   (clk),
		.we    (wr.lw_en),
		.waddr (wr.lw_addr),
		.wdata (wr.lw_data),
		.re    (en1),
		.raddr (req.operand_b),
		.rdata (log_b_raw)
	);

	// stage 1 control and operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= req_valid & ~busy;
		end
	end

	// log of zero and unreached entries read as zero
	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1 <= req.command;
			a_s1   <= req.operand_a;
			b_s1   <= req.operand_b;
			va_s1  <= lval[req.operand_a] & (req.operand_a != '0);
			vb_s1  <= lval[req.operand_b] & (req.operand_b != '0);
		end
	end

	assign la = va_s1 ? log_a_raw : '0;
	assign lb = vb_s1 ? log_b_raw : '0;

	// exponent sum modulo the group order
	assign lsum     = {1'b0, la} + {1'b0, lb};
	assign lsum_red = (lsum >= GROUP_ORDER) ? (lsum - GROUP_ORDER) : lsum;

	// power table address per operation
	always_comb begin
		case (cmd_s1)
			CMD_MUL:   pw_addr = lsum_red[ELEM_W-1:0];
			CMD_INV:   pw_addr = ~la;
			CMD_ALPHA: pw_addr = a_s1;
			default:   pw_addr = a_s1;
		endcase
	end

	gfau_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_power (
		.clk   (clk),
		.we    (wr.pw_en),
		.waddr (wr.pw_addr),
		.wdata (wr.pw_data),
		.re    (en2),
		.raddr (pw_addr),
		.rdata (pw_data)
	);

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			cmd_s2 <= cmd_s1;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
		end
	end

	// result select with the zero and unit shortcuts
	always_comb begin
		res.zero_inverse_error = 1'b0;
		case (cmd_s2)
			CMD_ADD: begin
				res.field_result = a_s2 ^ b_s2;
			end
			CMD_MUL: begin
				if (a_s2 == '0 || b_s2 == '0) begin
					res.field_result = '0;
				end else if (a_s2 == 8'd1) begin
					res.field_result = b_s2;
				end else if (b_s2 == 8'd1) begin
					res.field_result = a_s2;
				end else begin
					res.field_result = pw_data;
				end
			end
			CMD_INV: begin
				if (a_s2 == '0) begin
					res.field_result       = '0;
					res.zero_inverse_error = 1'b1;
				end else begin
					res.field_result = pw_data;
				end
			end
			default: begin
				res.field_result = pw_data;
			end
		endcase
	end

	// stage 3, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			rsp_s3 <= res;
		end
	end

	assign rsp_valid = v3_s3;
	assign rsp       = rsp_s3;

endmodule

`default_nettype wire

FILE: src/gf256_arithmetic_unit.sv
// An accepted item passes the stage 1, 2 and 3 registers to reach rsp_valid.
// Throughput: one item per cycle; the log, power and select stages each hold
// one item and stall back from the response side without loss.
// Reset (arst_n low, asynchronous) loads polynomial 0x11D and starts a table
// build; a polynomial write restarts it. A build takes 256 accepted items,
// with no response; each writes a power entry, all but the last a log entry.
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit
// GF(256) add, multiply, inverse and alpha power on log and power tables
// built from a programmable field polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_arithmetic_unit import gfau_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        req_valid,
	input  req_item_t        req,
	output logic             req_stall,
	// response channel
	output logic             rsp_valid,
	output rsp_item_t        rsp,
	input  wire logic        rsp_stall,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [POLY_W-1:0]      poly_q;
	logic                   cfg_wr;
	logic                   poly_wr;
	logic                   req_acc;
	bld_wr_t                bwr;
	bld_stat_t              bst;
	logic [TABLE_DEPTH-1:0] lval;

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign poly_wr = cfg_wr & (paddr[2] == REG_FIELD_POLY);
	assign prdata  = (paddr[2] == REG_FIELD_POLY) ? {23'b0, poly_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
		end else if (poly_wr) begin
			poly_q <= pwdata[POLY_W-1:0];
		end
	end

	assign req_acc = req_valid & ~req_stall;

	// table builder
	gfau_builder u_builder (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (poly_wr),
		.poly    (poly_q),
		.step    (req_acc),
		.wr      (bwr),
		.stat    (bst),
		.lval    (lval)
	);

	// operation pipeline
	gfau_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_stall (rsp_stall),
		.busy      (bst.busy),
		.lval      (lval),
		.wr        (bwr)
	);

	// an error response always carries a zero element
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.zero_inverse_error |-> rsp.field_result == '0)
		else $error("inverse error with nonzero result");

	// tables are ready only at the final build index
	a_ready_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!bst.busy |-> bst.index == BUILD_DONE)
		else $error("builder idle at wrong index");

	// each item taken during a build advances it by one step
	a_build_step: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && bst.busy && !poly_wr |=> bst.index == $past(bst.index) + 9'd1)
		else $error("build step lost");

	// a polynomial write restarts the build
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		poly_wr |=> bst.busy && bst.index == '0)
		else $error("build did not restart");

endmodule

`default_nettype wire
